// ----- src/cell_matrix_inverse_3x3_unit_defines.svh -----
// Assertion macros for the 3x3 cell matrix inverse unit
`ifndef CELL_MATRIX_INVERSE_3X3_UNIT_DEFINES_SVH
`define CELL_MATRIX_INVERSE_3X3_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define CMI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CMI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cmi_pkg.sv -----
// Shared constants, types and tables for the 3x3 cell matrix inverse unit
package cmi_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_ELEM   = 9;
    localparam int PER_W      = 3;
    localparam int PROD_N     = 18;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int COF_W      = PROD_W + 1;
    localparam int SUM_W      = COF_W + 2;
    localparam int DET_W      = COF_W + DATA_WIDTH;
    localparam int MAG_W      = DET_W - 1;
    localparam int NUM_W      = PROD_W;
    localparam int QUO_W      = 2 * FRAC_BITS;
    localparam int OUT_DET_W  = 64;
    localparam int SH_W       = MAG_W - FRAC_BITS;
    localparam int FR_STAGES  = 6;
    localparam int DIV_STAGES = QUO_W + 1;
    localparam int TDATA_W    = NUM_ELEM * DATA_WIDTH + OUT_DET_W;

    // periodicity codes
    localparam logic [PER_W-1:0] PER_DIAG_0 = PER_W'(0);
    localparam logic [PER_W-1:0] PER_DIAG_1 = PER_W'(1);
    localparam logic [PER_W-1:0] PER_BLOCK  = PER_W'(2);
    localparam logic [PER_W-1:0] PER_FULL   = PER_W'(3);
    localparam logic [PER_W-1:0] PER_DIAG_4 = PER_W'(4);
    localparam logic [PER_W-1:0] PER_RESET  = PER_FULL;

    // lanes produced by the reduced modes (entries 1,2,4,5,9 and 1,5,9)
    localparam logic [NUM_ELEM-1:0] ACT_BLOCK = NUM_ELEM'(9'b1_0001_1011);
    localparam logic [NUM_ELEM-1:0] ACT_DIAG  = NUM_ELEM'(9'b1_0001_0001);

    // product index of entry 1 times entry 5
    localparam int PROD_15 = 4;

    // operand pairs of the 18 cofactor products (0-based entries)
    localparam int unsigned PROD_A [PROD_N] =
        '{4, 7, 0, 6, 0, 3, 6, 3, 2, 1, 3, 6, 1, 2, 6, 7, 2, 5};
    localparam int unsigned PROD_B [PROD_N] =
        '{8, 5, 8, 2, 4, 1, 5, 8, 7, 8, 7, 4, 5, 4, 1, 0, 3, 0};
    // product pair that forms the cofactor of each inverse entry
    localparam int unsigned COF_J [NUM_ELEM] = '{0, 4, 6, 3, 1, 8, 5, 7, 2};

    localparam logic [DATA_WIDTH-1:0] INV_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] INV_MAX = ~INV_MIN;
    localparam logic [OUT_DET_W-1:0]  DET_MIN = {1'b1, {(OUT_DET_W-1){1'b0}}};
    localparam logic [OUT_DET_W-1:0]  DET_MAX = ~DET_MIN;

    typedef logic [NUM_ELEM-1:0][DATA_WIDTH-1:0] t_mat;

    // numerator and denominator sources, carried beside the determinant
    typedef struct packed {
        logic [NUM_ELEM-1:0][COF_W-1:0] num;
        logic [NUM_ELEM-1:0][COF_W-1:0] den;
        logic                           use_det;
        logic [NUM_ELEM-1:0]            act;
        logic                           bad;
    } t_op;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [MAG_W-1:0] den;
        logic             neg;
        logic             act;
    } t_mag_lane;

    typedef struct packed {
        t_mag_lane [NUM_ELEM-1:0] lane;
        logic [MAG_W-1:0]         det_mag;
        logic                     det_neg;
        logic                     sing;
    } t_mag_word;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
        logic             act;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [NUM_ELEM-1:0] lane;
        logic [OUT_DET_W-1:0]     det;
        logic                     sing;
    } t_div_word;

endpackage

// ----- src/cmi_front.sv -----
// Front pipeline: products, cofactors, determinant and divider operands
module cmi_front
    import cmi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [PER_W-1:0] i_per,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_mat             i_mat,
    output logic             o_valid,
    input  logic             i_ready,
    output t_mag_word        o_word
);

    logic [FR_STAGES-1:0] r_vld;
    logic [FR_STAGES-1:0] n_vld;
    logic [FR_STAGES-1:0] en;

    assign en[FR_STAGES-1] = ~r_vld[FR_STAGES-1] | i_ready;
    for (genvar k = 0; k < FR_STAGES - 1; k++) begin : g_en
        assign en[k] = ~r_vld[k] | en[k+1];
    end
    assign n_vld   = {r_vld[FR_STAGES-2:0], i_valid};
    assign o_ready = en[0];
    assign o_valid = r_vld[FR_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (n_vld & en) | (r_vld & ~en);
        end
    end

    // stage A: eighteen entry products
    logic signed [PROD_W-1:0] n_a_p [PROD_N];
    logic signed [PROD_W-1:0] r_a_p [PROD_N];
    t_mat                     r_a_m;
    logic [PER_W-1:0]         r_a_per;

    always_comb begin
        for (int j = 0; j < PROD_N; j++) begin
            n_a_p[j] = $signed(i_mat[PROD_A[j]]) * $signed(i_mat[PROD_B[j]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_p   <= n_a_p;
            r_a_m   <= i_mat;
            r_a_per <= i_per;
        end
    end

    // stage B: cofactors, determinant operands, mode selection
    logic signed [COF_W-1:0]      cof [NUM_ELEM];
    logic signed [COF_W-1:0]      a_x [NUM_ELEM];
    logic signed [COF_W-1:0]      n_b_x [3];
    logic signed [DATA_WIDTH-1:0] n_b_y [3];
    t_op                          n_b_op;
    logic signed [COF_W-1:0]      r_b_x [3];
    logic signed [DATA_WIDTH-1:0] r_b_y [3];
    t_op                          r_b_op;

    always_comb begin
        for (int i = 0; i < NUM_ELEM; i++) begin
            cof[i] = COF_W'(r_a_p[2*COF_J[i]]) - COF_W'(r_a_p[2*COF_J[i]+1]);
            a_x[i] = COF_W'($signed(r_a_m[i]));
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_b_x[k] = '0;
            n_b_y[k] = '0;
        end
        n_b_op = '0;
        unique case (r_a_per)
            PER_FULL: begin
                n_b_x[0] = cof[0];
                n_b_y[0] = $signed(r_a_m[0]);
                n_b_x[1] = cof[1];
                n_b_y[1] = $signed(r_a_m[3]);
                n_b_x[2] = cof[2];
                n_b_y[2] = $signed(r_a_m[6]);
                for (int i = 0; i < NUM_ELEM; i++) begin
                    n_b_op.num[i] = cof[i];
                end
                n_b_op.use_det = 1'b1;
                n_b_op.act     = '1;
            end
            PER_BLOCK: begin
                // 2x2 block determinant times entry 9
                n_b_x[0]      = cof[8];
                n_b_y[0]      = $signed(r_a_m[8]);
                n_b_op.num[0] = a_x[4];
                n_b_op.num[1] = -a_x[1];
                n_b_op.num[3] = -a_x[3];
                n_b_op.num[4] = a_x[0];
                n_b_op.num[8] = COF_W'(1);
                n_b_op.den[0] = cof[8];
                n_b_op.den[1] = cof[8];
                n_b_op.den[3] = cof[8];
                n_b_op.den[4] = cof[8];
                n_b_op.den[8] = a_x[8];
                n_b_op.act    = ACT_BLOCK;
            end
            PER_DIAG_0, PER_DIAG_1, PER_DIAG_4: begin
                n_b_x[0]      = COF_W'(r_a_p[PROD_15]);
                n_b_y[0]      = $signed(r_a_m[8]);
                n_b_op.num[0] = COF_W'(1);
                n_b_op.num[4] = COF_W'(1);
                n_b_op.num[8] = COF_W'(1);
                n_b_op.den[0] = a_x[0];
                n_b_op.den[4] = a_x[4];
                n_b_op.den[8] = a_x[8];
                n_b_op.act    = ACT_DIAG;
            end
            default: begin
                n_b_op.bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_x  <= n_b_x;
            r_b_y  <= n_b_y;
            r_b_op <= n_b_op;
        end
    end

    // stage C: split the wide cofactor into two partial products
    logic signed [COF_W-1:0] n_c_pl [3];
    logic signed [COF_W-1:0] n_c_ph [3];
    logic signed [COF_W-1:0] r_c_pl [3];
    logic signed [COF_W-1:0] r_c_ph [3];
    t_op                     r_c_op;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c_pl[k] = $signed({1'b0, r_b_x[k][DATA_WIDTH-1:0]}) * r_b_y[k];
            n_c_ph[k] = $signed(r_b_x[k][COF_W-1:DATA_WIDTH]) * r_b_y[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_c_pl <= n_c_pl;
            r_c_ph <= n_c_ph;
            r_c_op <= r_b_op;
        end
    end

    // stage D: sum the partial products of the three terms
    logic signed [SUM_W-1:0] n_d_pl;
    logic signed [SUM_W-1:0] n_d_ph;
    logic signed [SUM_W-1:0] r_d_pl;
    logic signed [SUM_W-1:0] r_d_ph;
    t_op                     r_d_op;

    assign n_d_pl = SUM_W'(r_c_pl[0]) + SUM_W'(r_c_pl[1]) + SUM_W'(r_c_pl[2]);
    assign n_d_ph = SUM_W'(r_c_ph[0]) + SUM_W'(r_c_ph[1]) + SUM_W'(r_c_ph[2]);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_d_pl <= n_d_pl;
            r_d_ph <= n_d_ph;
            r_d_op <= r_c_op;
        end
    end

    // stage E: exact determinant
    logic signed [DET_W-1:0] pl_ext;
    logic signed [DET_W-1:0] ph_sh;
    logic signed [DET_W-1:0] r_e_det;
    t_op                     r_e_op;

    assign pl_ext = DET_W'(r_d_pl);
    assign ph_sh  = {r_d_ph[DET_W-DATA_WIDTH-1:0], {DATA_WIDTH{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_e_det <= ph_sh + pl_ext;
            r_e_op  <= r_d_op;
        end
    end

    // stage F: sign and magnitude of every operand
    logic signed [DET_W-1:0] den_full [NUM_ELEM];
    logic signed [COF_W-1:0] num_s    [NUM_ELEM];
    t_mag_word               n_f;
    t_mag_word               r_f;

    always_comb begin
        for (int i = 0; i < NUM_ELEM; i++) begin
            den_full[i] = r_e_op.use_det ? r_e_det : DET_W'($signed(r_e_op.den[i]));
            num_s[i]    = $signed(r_e_op.num[i]);
            n_f.lane[i].den = den_full[i][DET_W-1] ? MAG_W'(-den_full[i])
                                                   : MAG_W'(den_full[i]);
            n_f.lane[i].num = num_s[i][COF_W-1] ? NUM_W'(-num_s[i]) : NUM_W'(num_s[i]);
            n_f.lane[i].neg = num_s[i][COF_W-1] ^ den_full[i][DET_W-1];
            n_f.lane[i].act = r_e_op.act[i];
        end
        n_f.det_neg = r_e_det[DET_W-1];
        n_f.det_mag = r_e_det[DET_W-1] ? MAG_W'(-r_e_det) : MAG_W'(r_e_det);
        n_f.sing    = r_e_op.bad | (r_e_det == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_f <= n_f;
        end
    end

    assign o_word = r_f;

endmodule

// ----- src/cmi_div.sv -----
// Nine-lane pipelined restoring divider, one quotient bit per stage
module cmi_div
    import cmi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_mag_word i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_word o_word
);

    function automatic t_div_lane div_step(input t_div_lane l);
        logic [MAG_W:0] two_r;
        t_div_lane      o;
        o     = l;
        two_r = {l.rem, 1'b0};
        if (two_r >= {1'b0, l.den}) begin
            o.rem = MAG_W'(two_r - {1'b0, l.den});
            o.quo = {l.quo[QUO_W-2:0], 1'b1};
        end else begin
            o.rem = two_r[MAG_W-1:0];
            o.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [DIV_STAGES-1:0] r_vld;
    logic [DIV_STAGES-1:0] n_vld;
    logic [DIV_STAGES-1:0] en;
    t_div_word             r_stg [DIV_STAGES];
    t_div_word             n_stg [DIV_STAGES];

    assign en[DIV_STAGES-1] = ~r_vld[DIV_STAGES-1] | i_ready;
    for (genvar k = 0; k < DIV_STAGES - 1; k++) begin : g_en
        assign en[k] = ~r_vld[k] | en[k+1];
    end
    assign n_vld   = {r_vld[DIV_STAGES-2:0], i_valid};
    assign o_ready = en[0];
    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_word  = r_stg[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (n_vld & en) | (r_vld & ~en);
        end
    end

    // setup: overflow check, remainder load, determinant truncation and saturation
    logic [SH_W-1:0] det_sh;

    always_comb begin
        for (int i = 0; i < NUM_ELEM; i++) begin
            n_stg[0].lane[i].rem = MAG_W'(i_word.lane[i].num);
            n_stg[0].lane[i].den = i_word.lane[i].den;
            n_stg[0].lane[i].quo = '0;
            n_stg[0].lane[i].neg = i_word.lane[i].neg;
            n_stg[0].lane[i].ovf = MAG_W'(i_word.lane[i].num) >= i_word.lane[i].den;
            n_stg[0].lane[i].act = i_word.lane[i].act;
        end
        det_sh = i_word.det_mag[MAG_W-1:FRAC_BITS];
        if (i_word.sing) begin
            n_stg[0].det = '0;
        end else if (i_word.det_neg) begin
            n_stg[0].det = (det_sh > SH_W'(DET_MIN)) ? DET_MIN
                                                       : OUT_DET_W'(-det_sh);
        end else begin
            n_stg[0].det = (det_sh > SH_W'(DET_MAX)) ? DET_MAX
                                                       : det_sh[OUT_DET_W-1:0];
        end
        n_stg[0].sing = i_word.sing;
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
        always_comb begin
            n_stg[k] = r_stg[k-1];
            for (int i = 0; i < NUM_ELEM; i++) begin
                n_stg[k].lane[i] = div_step(r_stg[k-1].lane[i]);
            end
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

endmodule

// ----- src/cell_matrix_inverse_3x3_unit.sv -----
// Top level of the 3x3 cell matrix inverse unit
//
//   Channel   Dir  Fields (low bit first)
//   -------   ---  ----------------------------------------------------------
//   s_axis    in   tdata: elem_1 .. elem_9, 32 bits each
//   m_axis    out  tdata: inv_1 .. inv_9 (32 each), determinant (64); tuser: singular
//   cfg       in   i_cfg_we / i_cfg_wdata: periodicity (3 bits)
//
// One matrix per cycle while m_axis is not stalled; the path runs through six front stages
// (products, cofactors, two partial-product stages, determinant, magnitudes), one
// divider setup stage, 32 radix-2 divider stages and the output register.
// Reset clears every valid bit and loads periodicity 3; there is no clearing pass.
// Every full stage holds while its successor holds, so bubbles close up under a stall.
`include "cell_matrix_inverse_3x3_unit_defines.svh"

module cell_matrix_inverse_3x3_unit
    import cmi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [PER_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // elem_1 .. elem_9
    input  logic [NUM_ELEM*DATA_WIDTH-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // inv_1 .. inv_9, determinant
    output logic [TDATA_W-1:0]    m_axis_tdata,
    // singular
    output logic [0:0]            m_axis_tuser
);

    logic [PER_W-1:0] r_per;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per <= PER_RESET;
        end else if (i_cfg_we) begin
            r_per <= i_cfg_wdata;
        end
    end

    logic      fr_valid;
    logic      dv_ready;
    t_mag_word fr_word;
    logic      dv_valid;
    logic      out_en;
    t_div_word dv_word;

    cmi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_per   (r_per),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mat   (t_mat'(s_axis_tdata)),
        .o_valid (fr_valid),
        .i_ready (dv_ready),
        .o_word  (fr_word)
    );

    cmi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (dv_ready),
        .i_word  (fr_word),
        .o_valid (dv_valid),
        .i_ready (out_en),
        .o_word  (dv_word)
    );

    // output register: saturate quotients, zero inactive lanes and singular results
    logic                 r_ovld;
    logic [TDATA_W-1:0]   r_odata;
    logic                 r_ouser;
    logic [TDATA_W-1:0]   n_odata;
    logic [QUO_W-1:0]     q;

    assign out_en = ~r_ovld | m_axis_tready;

    always_comb begin
        n_odata = '0;
        for (int i = 0; i < NUM_ELEM; i++) begin
            q = dv_word.lane[i].quo;
            if (!dv_word.lane[i].act || dv_word.sing) begin
                n_odata[i*DATA_WIDTH +: DATA_WIDTH] = '0;
            end else if (dv_word.lane[i].neg) begin
                n_odata[i*DATA_WIDTH +: DATA_WIDTH] =
                    (dv_word.lane[i].ovf || q > QUO_W'(INV_MIN)) ? INV_MIN
                                                                 : DATA_WIDTH'(-q);
            end else begin
                n_odata[i*DATA_WIDTH +: DATA_WIDTH] =
                    (dv_word.lane[i].ovf || q > QUO_W'(INV_MAX)) ? INV_MAX
                                                                 : DATA_WIDTH'(q);
            end
        end
        n_odata[NUM_ELEM*DATA_WIDTH +: OUT_DET_W] = dv_word.det;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (out_en) begin
            r_ovld <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_odata <= n_odata;
            r_ouser <= dv_word.sing;
        end
    end

    assign m_axis_tvalid   = r_ovld;
    assign m_axis_tdata    = r_odata;
    assign m_axis_tuser[0] = r_ouser;

    `CMI_ASSERT_NOW(a_sing_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "singular result with nonzero fields")
    `CMI_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input held off without output backpressure")
    `CMI_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid, "output lost while pipeline was full")

endmodule

// ----- test/tb_cell_matrix_inverse_3x3_unit.sv -----
// Self-checking testbench for the 3x3 cell matrix inverse unit: directed table, then random matrices
`timescale 1ns / 1ps

module tb_cell_matrix_inverse_3x3_unit;
    import cmi_pkg::*;

    localparam logic [PER_W-1:0] PER_UNUSED_5 = PER_W'(5);
    localparam logic [PER_W-1:0] PER_UNUSED_6 = PER_W'(6);
    localparam logic [PER_W-1:0] PER_UNUSED_7 = PER_W'(7);
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 1630;

    typedef struct packed {
        t_mat                 inv;
        logic [OUT_DET_W-1:0] det;
        logic                 sing;
    } t_inverse;

    typedef struct {
        logic [PER_W-1:0] per;
        t_mat             mat;
        bit               typed;
        t_inverse         result;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [PER_W-1:0]             i_cfg_wdata;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [NUM_ELEM*DATA_WIDTH-1:0] s_axis_tdata;   // elem_1 .. elem_9
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [TDATA_W-1:0]           m_axis_tdata;     // inv_1 .. inv_9, determinant
    logic [0:0]                   m_axis_tuser;     // singular

    t_inverse         inverse_q[$];
    t_row             rows[$];
    logic [PER_W-1:0] cur_per;
    int               err_count;
    int               result_count;
    int               sing_count;

    cell_matrix_inverse_3x3_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [127:0] mag128(logic signed [127:0] x);
        return (x < 0) ? -x : x;
    endfunction

    // trunc(num * 2^32 / den), saturated to a signed Q16.16 entry
    function automatic logic [DATA_WIDTH-1:0] quot_q16(logic signed [127:0] num,
                                                      logic signed [127:0] den);
        logic         neg;
        logic [127:0] q;
        neg = (num < 0) != (den < 0);
        q   = (mag128(num) << (2 * FRAC_BITS)) / mag128(den);
        if (neg)
            return (q > 128'h8000_0000) ? INV_MIN : DATA_WIDTH'(-q);
        return (q > 128'h7FFF_FFFF) ? INV_MAX : DATA_WIDTH'(q);
    endfunction

    function automatic t_inverse predict_inverse(t_mat m, logic [PER_W-1:0] per);
        logic signed [127:0] a [1:9];
        logic signed [127:0] cof [1:9];
        logic signed [127:0] det;
        logic signed [127:0] blk;
        logic [127:0]        dm;
        t_inverse            r;
        r = '0;
        det = 0;
        for (int i = 1; i <= 9; i++)
            a[i] = $signed(m[i-1]);
        case (per)
            PER_FULL: begin
                cof[1] = a[5] * a[9] - a[8] * a[6];
                cof[5] = a[1] * a[9] - a[7] * a[3];
                cof[9] = a[1] * a[5] - a[4] * a[2];
                cof[4] = a[7] * a[6] - a[4] * a[9];
                cof[2] = a[3] * a[8] - a[2] * a[9];
                cof[7] = a[4] * a[8] - a[7] * a[5];
                cof[3] = a[2] * a[6] - a[3] * a[5];
                cof[8] = a[7] * a[2] - a[8] * a[1];
                cof[6] = a[3] * a[4] - a[6] * a[1];
                det = cof[1] * a[1] + cof[2] * a[4] + cof[3] * a[7];
                if (det != 0)
                    for (int i = 1; i <= 9; i++)
                        r.inv[i-1] = quot_q16(cof[i], det);
            end
            PER_BLOCK: begin
                blk = a[1] * a[5] - a[4] * a[2];
                det = blk * a[9];
                if (det != 0) begin
                    r.inv[0] = quot_q16(a[5], blk);
                    r.inv[4] = quot_q16(a[1], blk);
                    r.inv[3] = quot_q16(-a[4], blk);
                    r.inv[1] = quot_q16(-a[2], blk);
                    r.inv[8] = quot_q16(1, a[9]);
                end
            end
            PER_DIAG_0, PER_DIAG_1, PER_DIAG_4: begin
                det = a[1] * a[5] * a[9];
                if (det != 0) begin
                    r.inv[0] = quot_q16(1, a[1]);
                    r.inv[4] = quot_q16(1, a[5]);
                    r.inv[8] = quot_q16(1, a[9]);
                end
            end
            default: begin
                r.sing = 1'b1;
                return r;
            end
        endcase
        if (det == 0) begin
            r.sing = 1'b1;
            return r;
        end
        // drop 16 of the 48 fraction bits to reach Q32.32
        dm = mag128(det) >> FRAC_BITS;
        if (det < 0)
            r.det = (dm > 128'h8000_0000_0000_0000) ? DET_MIN : OUT_DET_W'(-dm);
        else
            r.det = (dm > 128'h7FFF_FFFF_FFFF_FFFF) ? DET_MAX : OUT_DET_W'(dm);
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_entry();
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2, 3, 4: return DATA_WIDTH'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
            5:       return DATA_WIDTH'($signed($urandom_range(2000)) - 1000);
            6:       return $urandom_range(1) ? INV_MAX : INV_MIN;
            7:       return 32'h0;
            8:       return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
            default: return DATA_WIDTH'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
        endcase
    endfunction

    function automatic t_mat rand_matrix();
        t_mat m;
        for (int i = 0; i < NUM_ELEM; i++)
            m[i] = rand_entry();
        // force a singular matrix now and then by repeating a row
        if ($urandom_range(15) == 0)
            m[8:6] = m[2:0];
        return m;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", result_count, field, got, want);
        err_count++;
    endtask

    // output monitor
    always @(posedge i_clk) begin
        t_inverse want;
        t_mat     got_inv;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_inv = m_axis_tdata[NUM_ELEM*DATA_WIDTH-1:0];
            if (inverse_q.size() == 0) begin
                $display("MISMATCH unexpected result transaction %0d", result_count);
                err_count++;
            end else begin
                want = inverse_q.pop_front();
                for (int i = 0; i < NUM_ELEM; i++)
                    if (got_inv[i] !== want.inv[i])
                        report_mismatch($sformatf("inv_%0d", i + 1), 64'(got_inv[i]),
                                        64'(want.inv[i]));
                if (m_axis_tdata[TDATA_W-1 -: OUT_DET_W] !== want.det)
                    report_mismatch("determinant", m_axis_tdata[TDATA_W-1 -: OUT_DET_W], want.det);
                if (m_axis_tuser[0] !== want.sing)
                    report_mismatch("singular", 64'(m_axis_tuser[0]), 64'(want.sing));
                if (want.sing)
                    sing_count++;
            end
            result_count++;
        end
    end

    // receiver stall pattern: rotate through always ready, light, heavy and periodic stalls
    always @(posedge i_clk) begin
        int slot;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            slot = int'(($time / 12 / 300) % 4);
            case (slot)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(3) != 0);
                2:       m_axis_tready <= ($urandom_range(3) == 0);
                default: m_axis_tready <= ($time / 12 / 7) % 3 != 0;
            endcase
        end
    end

    task automatic send_matrix(t_mat m, t_inverse want, bit typed);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= m;
        do @(posedge i_clk); while (!s_axis_tready);
        inverse_q.push_back(typed ? want : predict_inverse(m, cur_per));
    endtask

    task automatic write_period(logic [PER_W-1:0] per);
        s_axis_tvalid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= per;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_per = per;
    endtask

    task automatic add_row(logic [PER_W-1:0] per, t_mat m, bit typed, t_inverse want);
        t_row r;
        r.per = per;
        r.mat = m;
        r.typed = typed;
        r.result = want;
        rows.push_back(r);
    endtask

    initial begin
        t_mat     ident;
        t_mat     m;
        t_inverse ident_res;
        t_inverse block_res;
        t_inverse sing_res;
        logic [PER_W-1:0] plan [12];
        int       burst;
        int       sent;

        plan = '{PER_BLOCK, PER_DIAG_0, PER_FULL, PER_DIAG_1, PER_UNUSED_5, PER_DIAG_4,
                 PER_FULL, PER_UNUSED_7, PER_BLOCK, PER_UNUSED_6, PER_DIAG_0, PER_FULL};
        err_count = 0;
        result_count = 0;
        sing_count = 0;
        cur_per = PER_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        ident = '0;
        ident[0] = 32'h0001_0000;
        ident[4] = 32'h0001_0000;
        ident[8] = 32'h0001_0000;
        ident_res = '0;
        ident_res.inv = ident;
        ident_res.det = 64'h0000_0001_0000_0000;
        sing_res = '0;
        sing_res.sing = 1'b1;
        block_res = ident_res;

        // reset periodicity is the full inverse
        add_row(PER_FULL, ident, 1, ident_res);
        add_row(PER_FULL, '0, 1, sing_res);
        add_row(PER_FULL, {NUM_ELEM{INV_MAX}}, 1, sing_res);
        add_row(PER_FULL, {NUM_ELEM{INV_MIN}}, 1, sing_res);
        m = '0; m[0] = INV_MAX; m[4] = INV_MIN; m[8] = INV_MAX;
        add_row(PER_FULL, m, 0, sing_res);
        // tiny determinant: raw 1 on the diagonal
        m = '0; m[0] = 32'h1; m[4] = 32'h1; m[8] = 32'h1;
        add_row(PER_FULL, m, 0, sing_res);
        m = {32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000,
             32'hFFFF_0000, 32'h0004_0000, 32'h0001_8000, 32'h0002_0000};
        add_row(PER_FULL, m, 0, sing_res);
        add_row(PER_FULL, {INV_MIN, INV_MAX, 32'h1, INV_MAX, INV_MIN, 32'hFFFF_FFFF,
                           32'h1, INV_MIN, INV_MAX}, 0, sing_res);
        add_row(PER_BLOCK, ident, 1, block_res);
        m = ident; m[8] = '0;
        add_row(PER_BLOCK, m, 1, sing_res);
        m = {INV_MIN, 32'h5, 32'h7, 32'h0002_0000, INV_MIN, 32'h9, 32'h3, INV_MAX, INV_MIN};
        add_row(PER_BLOCK, m, 0, sing_res);
        add_row(PER_DIAG_0, ident, 1, ident_res);
        m = ident; m[0] = 32'h0002_0000; m[4] = 32'h0004_0000; m[8] = 32'hFFFF_0000;
        add_row(PER_DIAG_0, m, 0, sing_res);
        m = ident; m[4] = '0;
        add_row(PER_DIAG_0, m, 1, sing_res);
        add_row(PER_DIAG_1, ident, 1, ident_res);
        add_row(PER_DIAG_4, ident, 1, ident_res);
        m = {INV_MIN, 32'h0, 32'h0, 32'h0, INV_MIN, 32'h0, 32'h0, 32'h0, INV_MIN};
        add_row(PER_DIAG_4, m, 0, sing_res);
        add_row(PER_UNUSED_5, ident, 1, sing_res);
        add_row(PER_UNUSED_6, ident, 1, sing_res);
        add_row(PER_UNUSED_7, ident, 1, sing_res);

        foreach (rows[i]) begin
            if (rows[i].per != cur_per)
                write_period(rows[i].per);
            send_matrix(rows[i].mat, rows[i].result, rows[i].typed);
        end

        // random part: bursts with gaps, one periodicity per phase
        sent = 0;
        foreach (plan[p]) begin
            write_period(plan[p]);
            for (int n = 0; n < RANDOM_ITEMS / 12; n += burst) begin
                burst = $urandom_range(1, 40);
                // trim the last burst of the phase
                if (burst > RANDOM_ITEMS / 12 - n)
                    burst = RANDOM_ITEMS / 12 - n;
                for (int k = 0; k < burst; k++) begin
                    send_matrix(rand_matrix(), sing_res, 0);
                    sent++;
                end
                if ($urandom_range(3) != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (inverse_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d directed and %0d random matrices over every periodicity setting,",
                 rows.size(), sent);
        $display("%0d results checked, %0d of them singular, %0d errors",
                 result_count, sing_count, err_count);
        if (err_count == 0)
            $display("tb_cell_matrix_inverse_3x3_unit: clean");
        else
            $display("tb_cell_matrix_inverse_3x3_unit: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", inverse_q.size());
        $display("tb_cell_matrix_inverse_3x3_unit: errors");
        $finish;
    end

endmodule
